### src/extendible_hash_table_defines.svh
// assertion macros shared by the checker
`ifndef EXTENDIBLE_HASH_TABLE_DEFINES_SVH
`define EXTENDIBLE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define EHT_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define EHT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### src/ehash_pkg.sv
package ehash_pkg;

   // request operations
   localparam logic [1:0] REQ_FIND   = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // result codes
   localparam logic [1:0] RC_OK     = 2'd0;
   localparam logic [1:0] RC_ABSENT = 2'd1;
   localparam logic [1:0] RC_NOROOM = 2'd2;

   // register map
   localparam logic       REG_CAPACITY = 1'b0;
   localparam logic [3:0] CAP_RESET    = 4'd4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] key;
   } ehash_req_type;

   typedef struct packed {
      logic [1:0] result_code;
      logic [3:0] depth_now;
   } ehash_rsp_type;

endpackage

### src/ehash_csr.sv
module ehash_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [3:0]  capacity
);
   import ehash_pkg::*;

   logic [3:0] cap_ff;
   logic [3:0] cap_in;

   // register write on the access phase
   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
         cap_in = pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // read back
   assign prdata   = (paddr[2] == REG_CAPACITY) ? {28'd0, cap_ff} : 32'd0;
   assign pready   = 1'b1;
   assign capacity = cap_ff;

endmodule

### src/extendible_hash_table.sv
// find: reads the directory entry, then the bucket's metadata, then compares its slots in turn
// remove: as find, then shifts later keys down and lowers the fill; insert with room adds the key
// a split repoints the directory, moves keys by the next bit, writes both fills, then retries
// a doubling first copies the directory into its upper half; an unused request type never sets busy
// busy drops with the result strobe, so the next transfer can be taken in that cycle
// reset runs a pass that sets up buckets 0 and 1 with busy high; the receiver cannot stall
module extendible_hash_table #(
   parameter int MAX_GLOBAL_DEPTH = 8,
   parameter int MAX_BUCKETS      = 256,
   parameter int BUCKET_SLOTS     = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  ehash_pkg::ehash_req_type req_data,
   output logic                    rsp_valid,
   output ehash_pkg::ehash_rsp_type rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import ehash_pkg::*;

   localparam int IW = MAX_GLOBAL_DEPTH;
   localparam int DW = $clog2(MAX_GLOBAL_DEPTH + 1);
   localparam int BW = $clog2(MAX_BUCKETS);
   localparam int UW = $clog2(MAX_BUCKETS + 1);
   localparam int FW = $clog2(BUCKET_SLOTS + 1);
   localparam int SW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
   localparam int MW = DW + FW;
   localparam int AW = BW + SW;

   // sequencer states
   localparam logic [4:0] S_INIT0     = 5'd0;
   localparam logic [4:0] S_INIT1     = 5'd1;
   localparam logic [4:0] S_IDLE      = 5'd2;
   localparam logic [4:0] S_DIR_RD    = 5'd3;
   localparam logic [4:0] S_DIR_WAIT  = 5'd4;
   localparam logic [4:0] S_META_WAIT = 5'd5;
   localparam logic [4:0] S_SCAN_RD   = 5'd6;
   localparam logic [4:0] S_SCAN_CMP  = 5'd7;
   localparam logic [4:0] S_SHIFT_RD  = 5'd8;
   localparam logic [4:0] S_SHIFT_WR  = 5'd9;
   localparam logic [4:0] S_REM_META  = 5'd10;
   localparam logic [4:0] S_DBL_RD    = 5'd11;
   localparam logic [4:0] S_DBL_WR    = 5'd12;
   localparam logic [4:0] S_SPLIT_DIR = 5'd13;
   localparam logic [4:0] S_SPLIT_RD  = 5'd14;
   localparam logic [4:0] S_SPLIT_WR  = 5'd15;
   localparam logic [4:0] S_SPLIT_M0  = 5'd16;
   localparam logic [4:0] S_SPLIT_M1  = 5'd17;

   // tables
   logic [BW-1:0] dir_ff  [2**IW];
   logic [MW-1:0] meta_ff [2**BW];
   logic [31:0]   slot_ff [2**AW];
   logic [BW-1:0] dir_q_ff;
   logic [MW-1:0] meta_q_ff;
   logic [31:0]   slot_q_ff;

   logic          dir_we, meta_we, slot_we;
   logic [IW-1:0] dir_waddr, dir_raddr;
   logic [BW-1:0] dir_wdata;
   logic [BW-1:0] meta_waddr, meta_raddr;
   logic [MW-1:0] meta_wdata;
   logic [AW-1:0] slot_waddr, slot_raddr;
   logic [31:0]   slot_wdata;

   // sequencer registers
   logic [4:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   key_ff, key_in;
   logic [DW-1:0] gd_ff, gd_in;
   logic [UW-1:0] used_ff, used_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [DW-1:0] ld_ff, ld_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] j_ff, j_in;
   logic [IW:0]   i_ff, i_in;
   logic [FW-1:0] cb_ff, cb_in;
   logic [FW-1:0] cn_ff, cn_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ehash_rsp_type rsp_ff, rsp_in;

   logic [3:0]    capacity;
   logic [FW-1:0] cap_eff;
   logic [DW-1:0] m_ld;
   logic [FW-1:0] m_fill;
   logic [IW:0]   size_w, bit_w, low_mask;
   logic [FW:0]   j_next;
   logic [IW:0]   i_next;

   ehash_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   // effective bucket capacity
   always_comb begin
      if (capacity == 4'd0) begin
         cap_eff = FW'(1);
      end else if (int'(capacity) > BUCKET_SLOTS) begin
         cap_eff = FW'(BUCKET_SLOTS);
      end else begin
         cap_eff = FW'(capacity);
      end
   end

   assign m_ld     = meta_q_ff[MW-1:FW];
   assign m_fill   = meta_q_ff[FW-1:0];
   assign size_w   = (IW+1)'(1) << gd_ff;
   assign bit_w    = (IW+1)'(1) << ld_ff;
   assign low_mask = bit_w - 1'b1;
   assign j_next   = {1'b0, j_ff} + 1'b1;
   assign i_next   = i_ff + 1'b1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      gd_in        = gd_ff;
      used_in      = used_ff;
      bkt_in       = bkt_ff;
      ld_in        = ld_ff;
      fill_in      = fill_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      cb_in        = cb_ff;
      cn_in        = cn_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      dir_we       = 1'b0;
      dir_waddr    = '0;
      dir_wdata    = '0;
      dir_raddr    = '0;
      meta_we      = 1'b0;
      meta_waddr   = '0;
      meta_wdata   = '0;
      meta_raddr   = '0;
      slot_we      = 1'b0;
      slot_waddr   = '0;
      slot_wdata   = key_ff;
      slot_raddr   = '0;
      case (state_ff)
         S_INIT0: begin
            dir_we     = 1'b1;
            meta_we    = 1'b1;
            meta_wdata = {DW'(1), FW'(0)};
            state_in   = S_INIT1;
         end
         S_INIT1: begin
            dir_we     = 1'b1;
            dir_waddr  = IW'(1);
            dir_wdata  = BW'(1);
            meta_we    = 1'b1;
            meta_waddr = BW'(1);
            meta_wdata = {DW'(1), FW'(0)};
            state_in   = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op_in  = req_data.req_type;
               key_in = req_data.key;
               if (req_data.req_type == REQ_FIND || req_data.req_type == REQ_INSERT ||
                   req_data.req_type == REQ_REMOVE) begin
                  state_in = S_DIR_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{RC_ABSENT, 4'(gd_ff)};
               end
            end
         end
         S_DIR_RD: begin
            dir_raddr = key_ff[IW-1:0] & IW'(size_w - 1'b1);
            state_in  = S_DIR_WAIT;
         end
         S_DIR_WAIT: begin
            bkt_in     = dir_q_ff;
            meta_raddr = dir_q_ff;
            state_in   = S_META_WAIT;
         end
         S_META_WAIT: begin
            ld_in   = m_ld;
            fill_in = m_fill;
            j_in    = '0;
            i_in    = '0;
            if (op_ff == REQ_INSERT) begin
               if (m_fill < cap_eff) begin
                  slot_we      = 1'b1;
                  slot_waddr   = {bkt_ff, SW'(m_fill)};
                  meta_we      = 1'b1;
                  meta_waddr   = bkt_ff;
                  meta_wdata   = {m_ld, m_fill + 1'b1};
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{RC_OK, 4'(gd_ff)};
                  state_in     = S_IDLE;
               end else if ((m_ld >= gd_ff && gd_ff >= DW'(MAX_GLOBAL_DEPTH)) ||
                            used_ff >= UW'(MAX_BUCKETS)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{RC_NOROOM, 4'(gd_ff)};
                  state_in     = S_IDLE;
               end else if (m_ld >= gd_ff) begin
                  state_in = S_DBL_RD;
               end else begin
                  state_in = S_SPLIT_DIR;
               end
            end else if (m_fill == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{RC_ABSENT, 4'(gd_ff)};
               state_in     = S_IDLE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            slot_raddr = {bkt_ff, SW'(j_ff)};
            state_in   = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (slot_q_ff == key_ff) begin
               if (op_ff == REQ_FIND) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{RC_OK, 4'(gd_ff)};
                  state_in     = S_IDLE;
               end else if (j_next < {1'b0, fill_ff}) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_REM_META;
               end
            end else if (j_next < {1'b0, fill_ff}) begin
               j_in     = FW'(j_next);
               state_in = S_SCAN_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{RC_ABSENT, 4'(gd_ff)};
               state_in     = S_IDLE;
            end
         end
         S_SHIFT_RD: begin
            slot_raddr = {bkt_ff, SW'(j_next)};
            state_in   = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            slot_we    = 1'b1;
            slot_waddr = {bkt_ff, SW'(j_ff)};
            slot_wdata = slot_q_ff;
            j_in       = FW'(j_next);
            if (j_next + 1'b1 < {1'b0, fill_ff}) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_REM_META;
            end
         end
         S_REM_META: begin
            meta_we      = 1'b1;
            meta_waddr   = bkt_ff;
            meta_wdata   = {ld_ff, fill_ff - 1'b1};
            rsp_valid_in = 1'b1;
            rsp_in       = '{RC_OK, 4'(gd_ff)};
            state_in     = S_IDLE;
         end
         // directory doubling: copy lower half into upper half
         S_DBL_RD: begin
            dir_raddr = i_ff[IW-1:0];
            state_in  = S_DBL_WR;
         end
         S_DBL_WR: begin
            dir_we    = 1'b1;
            dir_waddr = IW'(size_w + i_ff);
            dir_wdata = dir_q_ff;
            if (i_next == size_w) begin
               i_in     = '0;
               gd_in    = gd_ff + 1'b1;
               state_in = S_SPLIT_DIR;
            end else begin
               i_in     = i_next;
               state_in = S_DBL_RD;
            end
         end
         // repoint the directory entries of the new bucket
         S_SPLIT_DIR: begin
            if (((i_ff & low_mask) == (IW+1)'(key_ff[IW-1:0] & low_mask[IW-1:0])) &&
                ((i_ff & bit_w) != '0)) begin
               dir_we    = 1'b1;
               dir_waddr = i_ff[IW-1:0];
               dir_wdata = BW'(used_ff);
            end
            i_in  = i_next;
            j_in  = '0;
            cb_in = '0;
            cn_in = '0;
            if (i_next == size_w) begin
               state_in = (fill_ff == '0) ? S_SPLIT_M0 : S_SPLIT_RD;
            end
         end
         // redistribute held keys by the next bit
         S_SPLIT_RD: begin
            slot_raddr = {bkt_ff, SW'(j_ff)};
            state_in   = S_SPLIT_WR;
         end
         S_SPLIT_WR: begin
            slot_we    = 1'b1;
            slot_wdata = slot_q_ff;
            if (slot_q_ff[ld_ff]) begin
               slot_waddr = {BW'(used_ff), SW'(cn_ff)};
               cn_in      = cn_ff + 1'b1;
            end else begin
               slot_waddr = {bkt_ff, SW'(cb_ff)};
               cb_in      = cb_ff + 1'b1;
            end
            j_in = FW'(j_next);
            if (j_next < {1'b0, fill_ff}) begin
               state_in = S_SPLIT_RD;
            end else begin
               state_in = S_SPLIT_M0;
            end
         end
         S_SPLIT_M0: begin
            meta_we    = 1'b1;
            meta_waddr = bkt_ff;
            meta_wdata = {ld_ff + 1'b1, cb_ff};
            state_in   = S_SPLIT_M1;
         end
         S_SPLIT_M1: begin
            meta_we    = 1'b1;
            meta_waddr = BW'(used_ff);
            meta_wdata = {ld_ff + 1'b1, cn_ff};
            used_in    = used_ff + 1'b1;
            state_in   = S_DIR_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT0;
         gd_ff        <= DW'(1);
         used_ff      <= UW'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gd_ff        <= gd_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      bkt_ff  <= bkt_in;
      ld_ff   <= ld_in;
      fill_ff <= fill_in;
      j_ff    <= j_in;
      i_ff    <= i_in;
      cb_ff   <= cb_in;
      cn_ff   <= cn_in;
      rsp_ff  <= rsp_in;
   end

   // table memories
   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_ff[dir_waddr] <= dir_wdata;
      end
      dir_q_ff <= dir_ff[dir_raddr];
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_ff[meta_waddr] <= meta_wdata;
      end
      meta_q_ff <= meta_ff[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_ff[slot_waddr] <= slot_wdata;
      end
      slot_q_ff <= slot_ff[slot_raddr];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/ehash_chk.sv
`include "extendible_hash_table_defines.svh"

module ehash_chk (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input ehash_pkg::ehash_rsp_type rsp_data
);
   import ehash_pkg::*;

   // an accepted transfer keeps the block busy or answers next cycle
   `EHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy || rsp_valid, "accepted item lost")

   // a result follows a busy cycle or an accepted transfer
   `EHT_ASSERT_NOW(a_rsp_cause, rsp_valid, $past(start || busy), "result without a transfer")

   // a result is shown only once the block is free again
   `EHT_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "result shown while busy")

   // result code stays within its meanings
   `EHT_ASSERT_NOW(a_rsp_code, rsp_valid,
      rsp_data.result_code == RC_OK || rsp_data.result_code == RC_ABSENT ||
      rsp_data.result_code == RC_NOROOM, "result code out of range")

endmodule

bind extendible_hash_table ehash_chk u_ehash_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
